@@ rtl/pwac_pkg.sv @@
// ----------------------------------------------------------------------------
// pwac_pkg
// Shared types, action codes and lookup tables of the pulse wave channel.
// ----------------------------------------------------------------------------
package pwac_pkg;

	// request action codes
	typedef enum logic [3:0] {
		ACT_CONTROL    = 4'd0,
		ACT_SWEEP_WR   = 4'd1,
		ACT_PERIOD_LO  = 4'd2,
		ACT_PERIOD_HI  = 4'd3,
		ACT_ENABLE     = 4'd4,
		ACT_TIMER_TICK = 4'd5,
		ACT_ENV_TICK   = 4'd6,
		ACT_SWEEP_TICK = 4'd7,
		ACT_LEN_TICK   = 4'd8
	} action_t;

	localparam logic [15:0] PERIOD_MIN = 16'd8;
	localparam logic [15:0] PERIOD_MAX = 16'h07FF;
	localparam logic [3:0]  ENV_FULL   = 4'd15;

	// request held in the input stage
	typedef struct packed {
		logic       valid;
		logic [3:0] action;
		logic [7:0] data;
	} item_t;

	// full channel state
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] timer_count;
		logic [2:0]  duty_step;
		logic [1:0]  duty_mode;
		logic [3:0]  volume_or_env_period;
		logic        env_enabled;
		logic        env_loop;
		logic        env_start;
		logic [3:0]  env_divider;
		logic [3:0]  env_volume;
		logic [2:0]  sweep_shift;
		logic        sweep_negate;
		logic        sweep_on;
		logic [3:0]  sweep_period;
		logic        sweep_reload;
		logic [3:0]  sweep_divider;
		logic [7:0]  length_count;
		logic        channel_on;
	} chan_state_t;

	// duty sequence bit, bit i of each pattern is step i
	function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
		logic [7:0] pat;
		case (mode)
			2'd0:    pat = 8'b0000_0010;
			2'd1:    pat = 8'b0000_0110;
			2'd2:    pat = 8'b0001_1110;
			default: pat = 8'b1111_1001;
		endcase
		return pat[step];
	endfunction

	// length counter load values
	function automatic logic [7:0] length_load(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:    v = 8'd10;
			5'd1:    v = 8'd254;
			5'd2:    v = 8'd20;
			5'd3:    v = 8'd2;
			5'd4:    v = 8'd40;
			5'd5:    v = 8'd4;
			5'd6:    v = 8'd80;
			5'd7:    v = 8'd6;
			5'd8:    v = 8'd160;
			5'd9:    v = 8'd8;
			5'd10:   v = 8'd60;
			5'd11:   v = 8'd10;
			5'd12:   v = 8'd14;
			5'd13:   v = 8'd12;
			5'd14:   v = 8'd26;
			5'd15:   v = 8'd14;
			5'd16:   v = 8'd12;
			5'd17:   v = 8'd16;
			5'd18:   v = 8'd24;
			5'd19:   v = 8'd18;
			5'd20:   v = 8'd48;
			5'd21:   v = 8'd20;
			5'd22:   v = 8'd96;
			5'd23:   v = 8'd22;
			5'd24:   v = 8'd192;
			5'd25:   v = 8'd24;
			5'd26:   v = 8'd72;
			5'd27:   v = 8'd26;
			5'd28:   v = 8'd16;
			5'd29:   v = 8'd28;
			5'd30:   v = 8'd32;
			default: v = 8'd30;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/pwac_in_reg.sv @@
// ----------------------------------------------------------------------------
// pwac_in_reg
// Input register: captures one request per cycle while the next stage moves.
// ----------------------------------------------------------------------------
module pwac_in_reg
	import pwac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [3:0] action,
	input  logic [7:0] write_data,
	input  logic       advance,
	output item_t      item_s1
);

	logic       valid_s1;
	logic [3:0] action_s1;
	logic [7:0] data_s1;

	// room when empty or when the held request moves on this cycle
	assign item_ready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1 <= action;
			data_s1   <= write_data;
		end
	end

	assign item_s1 = '{valid: valid_s1, action: action_s1, data: data_s1};

endmodule

@@ rtl/pwac_chan_state.sv @@
// ----------------------------------------------------------------------------
// pwac_chan_state
// Channel state registers with the per-request update and output level.
// ----------------------------------------------------------------------------
module pwac_chan_state
	import pwac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item_s1,
	input  logic       advance,
	input  logic       first_channel_q,
	output logic [3:0] sample_next
);

	chan_state_t st_q;
	chan_state_t st_d;
	logic [15:0] delta;
	logic [15:0] swept;

	// sweep target, wraps modulo 2^16
	always_comb begin
		delta = st_q.period >> st_q.sweep_shift;
		if (st_q.sweep_negate) begin
			swept = st_q.period - delta - {15'd0, first_channel_q};
		end else begin
			swept = st_q.period + delta;
		end
	end

	// next state for the held request
	always_comb begin
		st_d = st_q;
		case (item_s1.action)
			ACT_CONTROL: begin
				st_d.volume_or_env_period = item_s1.data[3:0];
				st_d.env_enabled          = !item_s1.data[4];
				st_d.env_loop             = item_s1.data[5];
				st_d.duty_mode            = item_s1.data[7:6];
				st_d.env_start            = 1'b1;
			end
			ACT_SWEEP_WR: begin
				st_d.sweep_shift  = item_s1.data[2:0];
				st_d.sweep_negate = item_s1.data[3];
				st_d.sweep_period = {1'b0, item_s1.data[6:4]} + 4'd1;
				st_d.sweep_on     = item_s1.data[7];
				st_d.sweep_reload = 1'b1;
			end
			ACT_PERIOD_LO: begin
				st_d.period[7:0] = item_s1.data;
			end
			ACT_PERIOD_HI: begin
				st_d.period[15:8] = {5'd0, item_s1.data[2:0]};
				if (st_q.channel_on) begin
					st_d.length_count = length_load(item_s1.data[7:3]);
				end
				st_d.env_start = 1'b1;
				st_d.duty_step = 3'd0;
			end
			ACT_ENABLE: begin
				st_d.channel_on = item_s1.data[0];
				if (!item_s1.data[0]) begin
					st_d.length_count = 8'd0;
				end
			end
			ACT_TIMER_TICK: begin
				if (st_q.timer_count == 16'd0) begin
					st_d.timer_count = st_q.period;
					st_d.duty_step   = st_q.duty_step + 3'd1;
				end else begin
					st_d.timer_count = st_q.timer_count - 16'd1;
				end
			end
			ACT_ENV_TICK: begin
				if (st_q.env_start) begin
					st_d.env_volume  = ENV_FULL;
					st_d.env_divider = st_q.volume_or_env_period;
					st_d.env_start   = 1'b0;
				end else if (st_q.env_divider != 4'd0) begin
					st_d.env_divider = st_q.env_divider - 4'd1;
				end else begin
					if (st_q.env_volume != 4'd0) begin
						st_d.env_volume = st_q.env_volume - 4'd1;
					end else if (st_q.env_loop) begin
						st_d.env_volume = ENV_FULL;
					end
					st_d.env_divider = st_q.volume_or_env_period;
				end
			end
			ACT_SWEEP_TICK: begin
				if (st_q.sweep_reload) begin
					if (st_q.sweep_on && st_q.sweep_divider == 4'd0) begin
						st_d.period = swept;
					end
					st_d.sweep_divider = st_q.sweep_period;
					st_d.sweep_reload  = 1'b0;
				end else if (st_q.sweep_divider != 4'd0) begin
					st_d.sweep_divider = st_q.sweep_divider - 4'd1;
				end else begin
					if (st_q.sweep_on) begin
						st_d.period = swept;
					end
					st_d.sweep_divider = st_q.sweep_period;
				end
			end
			ACT_LEN_TICK: begin
				if (!st_q.env_loop && st_q.length_count != 8'd0) begin
					st_d.length_count = st_q.length_count - 8'd1;
				end
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	// output level from the updated state
	always_comb begin
		if (!st_d.channel_on || st_d.length_count == 8'd0 ||
		    !duty_bit(st_d.duty_mode, st_d.duty_step) ||
		    st_d.period < PERIOD_MIN || st_d.period > PERIOD_MAX) begin
			sample_next = 4'd0;
		end else if (st_d.env_enabled) begin
			sample_next = st_d.env_volume;
		end else begin
			sample_next = st_d.volume_or_env_period;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	// disabling clears the length counter
	a_enable_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.action == ACT_ENABLE && !item_s1.data[0]
		|=> st_q.length_count == 8'd0 && !st_q.channel_on)
		else $error("length count not cleared on disable");

	// a timer tick at zero reloads from the period
	a_timer_reload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.action == ACT_TIMER_TICK && st_q.timer_count == 16'd0
		|=> st_q.timer_count == $past(st_q.period))
		else $error("timer did not reload");

	// state only moves with a request
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("state changed without a request");

endmodule

@@ rtl/pwac_out_reg.sv @@
// ----------------------------------------------------------------------------
// pwac_out_reg
// Result register holding one sample until the consumer takes it.
// ----------------------------------------------------------------------------
module pwac_out_reg
	import pwac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [3:0] sample_next,
	output logic       out_free,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [3:0] sample
);

	logic       valid_q;
	logic [3:0] sample_q;

	// free when empty or being taken this cycle
	assign out_free     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign sample       = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= sample_next;
		end
	end

endmodule

@@ rtl/pulse_wave_audio_channel_core.sv @@
// ----------------------------------------------------------------------------
// pulse_wave_audio_channel_core
// Square-wave audio channel with sweep, envelope and length counter.
//
//   channel   signals                               carries
//   request   item_valid / item_ready               action, write_data
//   result    result_valid / result_ready           sample
//   config    cfg_valid / cfg_ready                 first_channel
//
// Each request passes the input register, then the state update, and its
// sample lands in the result register. One request is accepted every cycle
// unless the result stalls; the state update is the only loop.
// Reset clears all channel state and sets first_channel to one.
// A stalled result holds the input register, which then holds item_ready low.
// ----------------------------------------------------------------------------
module pulse_wave_audio_channel_core
	import pwac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [3:0] action,
	input  logic [7:0] write_data,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [3:0] sample,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       first_channel
);

	item_t      item_s1;
	logic       advance;
	logic       out_free;
	logic       first_channel_q;
	logic [3:0] sample_next;

	// configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_channel_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			first_channel_q <= first_channel;
		end
	end

	// held request moves when the result register has room
	assign advance = item_s1.valid && out_free;

	pwac_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.action     (action),
		.write_data (write_data),
		.advance    (advance),
		.item_s1    (item_s1)
	);

	pwac_chan_state u_chan_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_s1         (item_s1),
		.advance         (advance),
		.first_channel_q (first_channel_q),
		.sample_next     (sample_next)
	);

	pwac_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.sample_next  (sample_next),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample       (sample)
	);

	// a blocked result must block the input side once a request is held
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		item_s1.valid && result_valid && !result_ready |-> !item_ready)
		else $error("request accepted while pipeline is full");

	// every accepted request is held in the input register next cycle
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> item_s1.valid)
		else $error("accepted request lost");

	// every processed request produces a result
	a_result_made: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed request gave no result");

endmodule
